// ===== rtl/drs_pkg.sv =====
// Shared types and constants of the depth-first route search block.
`default_nettype none

package drs_pkg;

    // Node indices travel in five bits, so at most this many nodes can ever be named.
    localparam int NODE_W     = 5;
    localparam int NODE_SPACE = 32;
    // Adjacency slot index; MAX_DEGREE is at most 32.
    localparam int SLOT_W     = 5;
    // The path stack holds this many nodes; its depth counter can hold the capacity itself.
    localparam int STACK_CAP  = 32;
    localparam int DEPTH_W    = 6;

    localparam int NUM_NODES_DEF  = 32;
    localparam int MAX_DEGREE_DEF = 8;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic [1:0] {
        STATUS_PATH_NODE  = 2'd0,
        STATUS_NO_ROUTE   = 2'd1,
        STATUS_EDGE_ADDED = 2'd2,
        STATUS_LIST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESULT,
        ST_SCAN,
        ST_CHECK,
        ST_POP,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    // Request from the search controller to the adjacency store.
    typedef struct packed {
        logic  wr_en;
        logic  rd_en;
        node_t node;
        slot_t slot;
        node_t wr_data;
    } adj_req_t;

endpackage

`default_nettype wire

// ===== rtl/drs_adj_store.sv =====
// Adjacency store: neighbour list memory and per-node degree counters.
`default_nettype none

module drs_adj_store #(
    parameter int NUM_NODES  = drs_pkg::NUM_NODES_DEF,
    parameter int MAX_DEGREE = drs_pkg::MAX_DEGREE_DEF,
    parameter int DEG_W      = $clog2(MAX_DEGREE + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire drs_pkg::adj_req_t req,
    input  wire drs_pkg::node_t   deg_node,
    output logic [DEG_W-1:0]      deg,
    output drs_pkg::node_t        rd_data
);

    localparam int SLOTS  = (NUM_NODES < drs_pkg::NODE_SPACE) ? NUM_NODES : drs_pkg::NODE_SPACE;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEPTH  = SLOTS * MAX_DEGREE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    drs_pkg::node_t    nbr_mem [DEPTH];
    logic [DEG_W-1:0]  degree_reg [SLOTS];
    drs_pkg::node_t    rd_data_reg;

    logic [IDX_W-1:0]  req_idx;
    logic [IDX_W-1:0]  deg_idx;
    logic [ADDR_W-1:0] addr;

    assign req_idx = req.node[IDX_W-1:0];
    assign deg_idx = deg_node[IDX_W-1:0];
    // Lists sit one after another, MAX_DEGREE entries per node.
    assign addr = ADDR_W'(ADDR_W'(req_idx) * ADDR_W'(MAX_DEGREE)) + ADDR_W'(req.slot);

    assign deg     = degree_reg[deg_idx];
    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            nbr_mem[addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= nbr_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                degree_reg[i] <= '0;
            end
        end else if (req.wr_en) begin
            degree_reg[req_idx] <= degree_reg[req_idx] + DEG_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dfs_route_search.sv =====
// Top level of the depth-first route search block: controller, path stack and output register.
// An add-edge item or a refused query passes through the result state, then the output register.
// A query pushes the origin, scans and checks per neighbour probe, scans and pops per backtrack,
// then emits each path node; it grows with the edges probed, each backtrack rescanning the list.
// Throughput: one item at a time; the next item is taken once the last result is registered.
// Reset: synchronous, active low; it clears the control state and all node degrees.
`default_nettype none

module dfs_route_search #(
    parameter int NUM_NODES  = drs_pkg::NUM_NODES_DEF,
    parameter int MAX_DEGREE = drs_pkg::MAX_DEGREE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [4:0] first_node, [9:5] second_node, rest zero
    input  wire logic [0:0]  s_tuser,   // [0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [4:0] node, rest zero
    output logic [1:0]       m_tuser,   // [1:0] status
    output logic             m_tlast    // last
);

    localparam int DEG_W = $clog2(MAX_DEGREE + 1);

    // Control state.
    drs_pkg::state_t  state_reg, state_next;
    drs_pkg::node_t   cur_reg, cur_next;
    drs_pkg::node_t   dst_reg, dst_next;
    logic [DEG_W-1:0] idx_reg, idx_next;
    logic [drs_pkg::DEPTH_W-1:0] depth_reg, depth_next;
    logic [drs_pkg::DEPTH_W-1:0] emit_k_reg, emit_k_next;
    drs_pkg::status_t res_status_reg, res_status_next;
    logic [drs_pkg::NODE_SPACE-1:0] visited_reg, visited_next;

    // Output register.
    logic             m_tvalid_reg, m_tvalid_next;
    drs_pkg::node_t   m_node_reg, m_node_next;
    drs_pkg::status_t m_status_reg, m_status_next;
    logic             m_last_reg, m_last_next;
    logic             out_load;
    drs_pkg::node_t   out_node;
    drs_pkg::status_t out_status;
    logic             out_last;

    // Path stack memory.
    drs_pkg::node_t   stack_mem [drs_pkg::STACK_CAP];
    drs_pkg::node_t   stack_rd_reg;
    logic             stack_we, stack_re;
    logic [4:0]       stack_waddr, stack_raddr;
    drs_pkg::node_t   stack_wdata;

    // Adjacency store.
    drs_pkg::adj_req_t adj_req;
    drs_pkg::node_t    deg_node;
    logic [DEG_W-1:0]  adj_deg;
    drs_pkg::node_t    adj_rd_data;

    // Input decode.
    logic           accept;
    logic           in_mode;
    drs_pkg::node_t in_a, in_b;
    logic           in_ok;
    logic           out_free;
    logic           emit_last;

    assign in_mode  = s_tuser[0];
    assign in_a     = s_tdata[4:0];
    assign in_b     = s_tdata[9:5];
    assign s_tready = (state_reg == drs_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // Indices at or above the graph size are refused or answer no route.
    assign in_ok    = (7'(in_a) < 7'(NUM_NODES)) && (7'(in_b) < 7'(NUM_NODES));
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit_last = ((emit_k_reg + drs_pkg::DEPTH_W'(1)) == depth_reg);

    // Degree lookup follows the incoming source while idle, the current node during a search.
    assign deg_node = (state_reg == drs_pkg::ST_IDLE) ? in_a : cur_reg;

    drs_adj_store #(
        .NUM_NODES  (NUM_NODES),
        .MAX_DEGREE (MAX_DEGREE),
        .DEG_W      (DEG_W)
    ) u_adj (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (adj_req),
        .deg_node (deg_node),
        .deg      (adj_deg),
        .rd_data  (adj_rd_data)
    );

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            drs_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_mode && in_ok) begin
                        state_next = drs_pkg::ST_SCAN;
                    end else begin
                        state_next = drs_pkg::ST_RESULT;
                    end
                end
            end
            drs_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = drs_pkg::ST_IDLE;
                end
            end
            drs_pkg::ST_SCAN: begin
                if (cur_reg == dst_reg) begin
                    state_next = drs_pkg::ST_EMIT_RD;
                end else if (idx_reg < adj_deg) begin
                    state_next = drs_pkg::ST_CHECK;
                end else if (depth_reg == drs_pkg::DEPTH_W'(1)) begin
                    state_next = drs_pkg::ST_RESULT;
                end else begin
                    state_next = drs_pkg::ST_POP;
                end
            end
            drs_pkg::ST_CHECK:   state_next = drs_pkg::ST_SCAN;
            drs_pkg::ST_POP:     state_next = drs_pkg::ST_SCAN;
            drs_pkg::ST_EMIT_RD: state_next = drs_pkg::ST_EMIT_WR;
            drs_pkg::ST_EMIT_WR: begin
                if (out_free) begin
                    state_next = emit_last ? drs_pkg::ST_IDLE : drs_pkg::ST_EMIT_RD;
                end
            end
            default: state_next = drs_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control for each state.
    always_comb begin
        cur_next        = cur_reg;
        dst_next        = dst_reg;
        idx_next        = idx_reg;
        depth_next      = depth_reg;
        emit_k_next     = emit_k_reg;
        res_status_next = res_status_reg;
        visited_next    = visited_reg;
        adj_req         = '0;
        stack_we        = 1'b0;
        stack_waddr     = '0;
        stack_wdata     = '0;
        stack_re        = 1'b0;
        stack_raddr     = '0;
        out_load        = 1'b0;
        out_node        = '0;
        out_status      = res_status_reg;
        out_last        = 1'b1;

        unique case (state_reg)
            drs_pkg::ST_IDLE: begin
                if (accept) begin
                    if (!in_mode) begin
                        // Append the target to the source list, or refuse when it is full or an index is out of range.
                        if (in_ok && (adj_deg < DEG_W'(MAX_DEGREE))) begin
                            adj_req.wr_en   = 1'b1;
                            adj_req.node    = in_a;
                            adj_req.slot    = drs_pkg::SLOT_W'(adj_deg);
                            adj_req.wr_data = in_b;
                            res_status_next = drs_pkg::STATUS_EDGE_ADDED;
                        end else begin
                            res_status_next = drs_pkg::STATUS_LIST_FULL;
                        end
                    end else if (in_ok) begin
                        // Fresh marks for every query; the origin is the stack's bottom.
                        visited_next       = '0;
                        visited_next[in_a] = 1'b1;
                        stack_we           = 1'b1;
                        stack_waddr        = '0;
                        stack_wdata        = in_a;
                        depth_next         = drs_pkg::DEPTH_W'(1);
                        cur_next           = in_a;
                        dst_next           = in_b;
                        idx_next           = '0;
                    end else begin
                        res_status_next = drs_pkg::STATUS_NO_ROUTE;
                    end
                end
            end
            drs_pkg::ST_RESULT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_node   = '0;
                    out_status = res_status_reg;
                    out_last   = 1'b1;
                end
            end
            drs_pkg::ST_SCAN: begin
                if (cur_reg == dst_reg) begin
                    emit_k_next = '0;
                end else if (idx_reg < adj_deg) begin
                    adj_req.rd_en = 1'b1;
                    adj_req.node  = cur_reg;
                    adj_req.slot  = drs_pkg::SLOT_W'(idx_reg);
                end else begin
                    // Dead end: drop the current node and return to its parent, or answer no route at the origin.
                    depth_next = depth_reg - drs_pkg::DEPTH_W'(1);
                    if (depth_reg == drs_pkg::DEPTH_W'(1)) begin
                        res_status_next = drs_pkg::STATUS_NO_ROUTE;
                    end else begin
                        stack_re    = 1'b1;
                        stack_raddr = 5'(depth_reg - drs_pkg::DEPTH_W'(2));
                    end
                end
            end
            drs_pkg::ST_CHECK: begin
                if (visited_reg[adj_rd_data]) begin
                    idx_next = idx_reg + DEG_W'(1);
                end else begin
                    visited_next[adj_rd_data] = 1'b1;
                    if (depth_reg < drs_pkg::DEPTH_W'(drs_pkg::STACK_CAP)) begin
                        stack_we    = 1'b1;
                        stack_waddr = depth_reg[4:0];
                        stack_wdata = adj_rd_data;
                        depth_next  = depth_reg + drs_pkg::DEPTH_W'(1);
                        cur_next    = adj_rd_data;
                        idx_next    = '0;
                    end else begin
                        // Full stack: the neighbour counts as a dead end.
                        idx_next = idx_reg + DEG_W'(1);
                    end
                end
            end
            drs_pkg::ST_POP: begin
                cur_next = stack_rd_reg;
                idx_next = '0;
            end
            drs_pkg::ST_EMIT_RD: begin
                stack_re    = 1'b1;
                stack_raddr = emit_k_reg[4:0];
            end
            drs_pkg::ST_EMIT_WR: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    out_node    = stack_rd_reg;
                    out_status  = drs_pkg::STATUS_PATH_NODE;
                    out_last    = emit_last;
                    emit_k_next = emit_k_reg + drs_pkg::DEPTH_W'(1);
                    if (emit_last) begin
                        depth_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: it is loaded only when empty or being drained.
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_node_next   = m_node_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_node_next   = out_node;
            m_status_next = out_status;
            m_last_next   = out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_node_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= drs_pkg::ST_IDLE;
            depth_reg    <= '0;
            visited_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            depth_reg    <= depth_next;
            visited_reg  <= visited_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        dst_reg        <= dst_next;
        idx_reg        <= idx_next;
        emit_k_reg     <= emit_k_next;
        res_status_reg <= res_status_next;
        m_node_reg     <= m_node_next;
        m_status_reg   <= m_status_next;
        m_last_reg     <= m_last_next;
    end

    // The stack is never read and written in the same cycle, so no forwarding is needed.
    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (stack_re) begin
            stack_rd_reg <= stack_mem[stack_raddr];
        end
    end

    // The stack depth never passes its capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= drs_pkg::DEPTH_W'(drs_pkg::STACK_CAP))
        else $error("path stack depth beyond capacity");

    // While the search walks, the origin at least stays on the stack.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == drs_pkg::ST_SCAN || state_reg == drs_pkg::ST_CHECK ||
         state_reg == drs_pkg::ST_POP) |-> (depth_reg != '0))
        else $error("search running with an empty stack");

    // Every node the search stands on has been marked visited.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == drs_pkg::ST_SCAN) |-> visited_reg[cur_reg])
        else $error("current node not marked visited");

    // One item at a time: an accepted item closes the input until its work is done.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in progress");

    // The final path result leaves the stack empty behind it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == drs_pkg::ST_EMIT_WR && out_free && emit_last) |=> (depth_reg == '0))
        else $error("stack not emptied after the path");

endmodule

`default_nettype wire
